@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is asserted
`define PCF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pcf assertion failed");

// clocked check, also active during reset
`define PCF_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("pcf assertion failed");

`endif

@@ rtl/pcf_pkg.sv @@
package pcf_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned CFG_ADDR_W  = 2;
	localparam int unsigned ROOT_STEPS  = 32;
	localparam logic [47:0] MASS_MAX    = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_CENTRE_X,
		CFG_CENTRE_Y,
		CFG_CENTRE_Z,
		CFG_CAPTURE_RADIUS
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [31:0]        mass;
		logic               last_particle;
	} in_t;

	typedef struct packed {
		logic        keep;
		logic        pass_done;
		logic [47:0] captured_mass;
		logic [31:0] new_radius;
	} out_t;

	typedef struct packed {
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic signed [31:0] centre_z;
		logic [61:0]        radius_sq;
	} cfg_t;

	typedef struct packed {
		logic        keep;
		logic        last;
		logic [63:0] dist_sq;
		logic [31:0] mass;
	} qent_t;

endpackage

@@ rtl/pcf_front.sv @@
module pcf_front import pcf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_stall,
	input  in_t   in_data,
	output logic  push,
	output qent_t push_data,
	input  logic  full
);

	function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		return d[32] ? 32'(~d + 33'd1) : d[31:0];
	endfunction

	logic        advance;
	logic        valid_s1, valid_s2, valid_s3;
	logic [31:0] mag_x_s1, mag_y_s1, mag_z_s1;
	logic [31:0] mass_s1, mass_s2, mass_s3;
	logic        last_s1, last_s2, last_s3;
	logic [63:0] sq_x_s2, sq_y_s2, sq_z_s2;
	logic [63:0] dist_s3;
	logic [63:0] sq_x, sq_y, sq_z;
	logic [65:0] sum;

	assign advance  = !(valid_s3 && full);
	assign in_stall = !advance;

	assign sq_x = mag_x_s1 * mag_x_s1;
	assign sq_y = mag_y_s1 * mag_y_s1;
	assign sq_z = mag_z_s1 * mag_z_s1;
	assign sum  = 66'(sq_x_s2) + 66'(sq_y_s2) + 66'(sq_z_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_x_s1 <= abs_diff(in_data.pos_x, cfg.centre_x);
			mag_y_s1 <= abs_diff(in_data.pos_y, cfg.centre_y);
			mag_z_s1 <= abs_diff(in_data.pos_z, cfg.centre_z);
			mass_s1  <= in_data.mass;
			last_s1  <= in_data.last_particle;
			sq_x_s2  <= sq_x;
			sq_y_s2  <= sq_y;
			sq_z_s2  <= sq_z;
			mass_s2  <= mass_s1;
			last_s2  <= last_s1;
			dist_s3  <= (sum[65:64] != 2'b00) ? '1 : sum[63:0];
			mass_s3  <= mass_s2;
			last_s3  <= last_s2;
		end
	end

	assign push              = valid_s3 && !full;
	assign push_data.keep    = dist_s3 >= 64'(cfg.radius_sq);
	assign push_data.last    = last_s3;
	assign push_data.dist_sq = dist_s3;
	assign push_data.mass    = mass_s3;

endmodule

@@ rtl/pcf_queue.sv @@
`include "assert_macros.svh"

module pcf_queue import pcf_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  pop_valid,
	output qent_t pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	qent_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PCF_ASSERT_ALWAYS(a_count_bound, clk, count_q <= CNT_W'(DEPTH))
	`PCF_ASSERT(a_no_overrun, clk, arst_n, full |-> !(push && !pop))
	`PCF_ASSERT(a_no_underrun, clk, arst_n, pop |-> pop_valid)

endmodule

@@ rtl/pcf_back.sv @@
`include "assert_macros.svh"

module pcf_back import pcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [30:0] capture_radius,
	input  logic        q_valid,
	input  qent_t       q_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data
);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_ROOT,
		ST_DONE
	} state_t;

	localparam logic [4:0] LAST_STEP = 5'(ROOT_STEPS - 1);

	state_t      state_q;
	logic        out_valid_q;
	out_t        out_q;
	logic [63:0] least_q;
	logic [47:0] mass_q;
	logic [63:0] rem_q, root_q, bit_q;
	logic [4:0]  step_q;
	logic        keep_hold_q;
	logic [47:0] mass_hold_q;

	logic        slot_free;
	logic        out_load;
	logic [63:0] least_next;
	logic [48:0] mass_sum;
	logic [47:0] mass_next;
	logic [64:0] trial;
	logic        take;
	logic [30:0] cand;

	assign slot_free  = !out_valid_q || !out_stall;
	assign pop        = (state_q == ST_RUN) && q_valid && slot_free;
	assign out_load   = (pop && !q_data.last) || (state_q == ST_DONE && slot_free);
	assign least_next = (q_data.keep && q_data.dist_sq < least_q) ? q_data.dist_sq : least_q;
	assign mass_sum   = {1'b0, mass_q} + {17'b0, q_data.mass};
	assign mass_next  = q_data.keep ? mass_q : (mass_sum[48] ? MASS_MAX : mass_sum[47:0]);
	assign trial      = {1'b0, root_q} + {1'b0, bit_q};
	assign take       = {1'b0, rem_q} >= trial;
	assign cand       = (root_q[31:1] < capture_radius) ? capture_radius : root_q[31:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
			least_q     <= '1;
			mass_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (pop) begin
						if (q_data.last) begin
							least_q     <= '1;
							mass_q      <= '0;
							rem_q       <= least_next;
							root_q      <= '0;
							bit_q       <= 64'd1 << 62;
							step_q      <= '0;
							keep_hold_q <= q_data.keep;
							mass_hold_q <= mass_next;
							state_q     <= ST_ROOT;
						end else begin
							least_q                <= least_next;
							mass_q                 <= mass_next;
							out_q.keep             <= q_data.keep;
							out_q.pass_done        <= 1'b0;
							out_q.captured_mass    <= '0;
							out_q.new_radius       <= '0;
						end
					end
				end
				ST_ROOT: begin
					if (take) begin
						rem_q  <= rem_q - trial[63:0];
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q  <= bit_q >> 2;
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						out_q.keep          <= keep_hold_q;
						out_q.pass_done     <= 1'b1;
						out_q.captured_mass <= mass_hold_q;
						out_q.new_radius    <= {1'b0, cand};
						state_q             <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PCF_ASSERT(a_pass_clears, clk, arst_n,
		(pop && q_data.last) |=> (least_q == '1 && mass_q == '0))
	`PCF_ASSERT(a_root_holds_queue, clk, arst_n, (state_q != ST_RUN) |-> !pop)
	`PCF_ASSERT(a_done_after_root, clk, arst_n,
		(state_q == ST_DONE && !$past(state_q == ST_DONE)) |-> $past(state_q == ST_ROOT))

endmodule

@@ rtl/particle_capture_filter.sv @@
// Particle capture filter. Each request carries one particle (position, mass, last-of-pass
// flag) and yields exactly one result in order: a keep flag and, on the last particle, the
// pass totals (captured mass, new radius); both accumulators then clear. Particles enter at
// one per cycle, unless stalled, into a three-stage distance pipeline (difference, square,
// saturating sum) that feeds a four-entry queue; the back end updates the min and mass
// accumulators at one per cycle while running with a free output register. The last
// particle of a pass holds the back end while a two-bit-per-step square root unit finishes;
// the queue absorbs up to four following particles meanwhile. Configuration writes are
// always taken (ready is tied high) and must be made while the block is idle.
module particle_capture_filter import pcf_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [31:0]           cfg_data
);

	logic signed [31:0] centre_x_q, centre_y_q, centre_z_q;
	logic [30:0]        radius_q;
	logic [61:0]        radius_sq_q;
	cfg_t               cfg;
	logic               push, full, pop, q_valid;
	qent_t              push_data, q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q  <= '0;
			centre_y_q  <= '0;
			centre_z_q  <= '0;
			radius_q    <= '0;
			radius_sq_q <= '0;
		end else begin
			radius_sq_q <= radius_q * radius_q;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_addr))
					CFG_CENTRE_X:       centre_x_q <= cfg_data;
					CFG_CENTRE_Y:       centre_y_q <= cfg_data;
					CFG_CENTRE_Z:       centre_z_q <= cfg_data;
					CFG_CAPTURE_RADIUS: radius_q   <= cfg_data[30:0];
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg.centre_x  = centre_x_q;
	assign cfg.centre_y  = centre_y_q;
	assign cfg.centre_z  = centre_z_q;
	assign cfg.radius_sq = radius_sq_q;

	pcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	pcf_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	pcf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.capture_radius (radius_q),
		.q_valid        (q_valid),
		.q_data         (q_data),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data)
	);

endmodule

@@ dv/pcf_checker.sv @@
`timescale 1ns / 100ps

module pcf_checker import pcf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_t                   in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_t                  out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [31:0]           cfg_data,
	output int                    fails,
	output int                    pending
);

	logic signed [31:0] centre_x;
	logic signed [31:0] centre_y;
	logic signed [31:0] centre_z;
	logic [30:0]        capture_radius;
	logic [63:0]        least_dist_sq;
	logic [47:0]        mass_total;
	out_t               due_results[$];

	function automatic logic [63:0] axis_sq(logic signed [31:0] p, logic signed [31:0] c);
		logic [32:0] d;
		logic [63:0] m;
		d = {p[31], p} - {c[31], c};
		if (d[32])
			d = ~d + 33'd1;
		m = {32'b0, d[31:0]};
		return m * m;
	endfunction

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [31:0] floor_root(logic [63:0] x);
		logic [31:0] r;
		logic [63:0] trial;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = {32'b0, r | (32'b1 << i)};
			if (trial * trial <= x)
				r = trial[31:0];
		end
		return r;
	endfunction

	// works out the result of one particle and moves the pass totals on
	function automatic out_t filter_particle(in_t p);
		out_t        res;
		logic [63:0] dist_sq;
		logic [63:0] rad_sq;
		logic [48:0] msum;
		logic [31:0] cand;
		dist_sq = axis_sq(p.pos_x, centre_x);
		dist_sq = sat_sum(dist_sq, axis_sq(p.pos_y, centre_y));
		dist_sq = sat_sum(dist_sq, axis_sq(p.pos_z, centre_z));
		rad_sq = {33'b0, capture_radius} * {33'b0, capture_radius};
		res = '0;
		res.keep = dist_sq >= rad_sq;
		res.pass_done = p.last_particle;
		if (res.keep) begin
			if (dist_sq < least_dist_sq)
				least_dist_sq = dist_sq;
		end else begin
			msum = {1'b0, mass_total} + {17'b0, p.mass};
			mass_total = msum[48] ? MASS_MAX : msum[47:0];
		end
		if (p.last_particle) begin
			cand = floor_root(least_dist_sq) >> 1;
			if (cand < {1'b0, capture_radius})
				cand = {1'b0, capture_radius};
			res.captured_mass = mass_total;
			res.new_radius = cand;
			least_dist_sq = '1;
			mass_total = '0;
		end
		return res;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			centre_x = '0;
			centre_y = '0;
			centre_z = '0;
			capture_radius = '0;
			least_dist_sq = '1;
			mass_total = '0;
			due_results.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_addr))
					CFG_CENTRE_X:       centre_x = cfg_data;
					CFG_CENTRE_Y:       centre_y = cfg_data;
					CFG_CENTRE_Z:       centre_z = cfg_data;
					CFG_CAPTURE_RADIUS: capture_radius = cfg_data[30:0];
					default:            ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with none expected, actual %0h", $time, out_data);
					fails++;
				end else begin
					want = due_results.pop_front();
					check_field("keep", want.keep, out_data.keep);
					check_field("pass_done", want.pass_done, out_data.pass_done);
					check_field("captured_mass", want.captured_mass, out_data.captured_mass);
					check_field("new_radius", want.new_radius, out_data.new_radius);
				end
			end
			if (in_valid && !in_stall)
				due_results.push_back(filter_particle(in_data));
			pending = due_results.size();
		end
	end

endmodule

@@ dv/particle_capture_filter_tb.sv @@
`timescale 1ns / 100ps

module particle_capture_filter_tb;
	import pcf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 150;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [31:0]           cfg_data;

	int          fail_count;
	int          pending_count;
	int          quiet_cycles;
	logic        calm;
	logic        hold_req;
	logic [31:0] cur_x;
	logic [31:0] cur_y;
	logic [31:0] cur_z;

	particle_capture_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	pcf_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.fails     (fail_count),
		.pending   (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("particle_capture_filter: mismatch");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// result side: random stalls, or one long hold-off when asked
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else
				out_stall <= !calm && ($urandom_range(99) < 11);
		end
	end

	function automatic in_t particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] m, logic last);
		in_t p;
		p.pos_x = x;
		p.pos_y = y;
		p.pos_z = z;
		p.mass = m;
		p.last_particle = last;
		return p;
	endfunction

	function automatic logic [31:0] scatter(logic [31:0] c);
		logic [31:0] off;
		off = $urandom;
		return c + 32'($signed(off) >>> $urandom_range(31));
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(3))
			0:       return 32'h0000_0000;
			1:       return 32'h8000_0000;
			2:       return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_radius();
		logic [31:0] r;
		case ($urandom_range(3))
			0:       r = 32'h0000_0000;
			1:       r = 32'h7FFF_FFFF;
			default: r = 32'($urandom) >> $urandom_range(31);
		endcase
		// top bit lies outside the register
		r[31] = $urandom_range(1);
		return r;
	endfunction

	// one request per call; valid stays up for a following request
	task automatic send_particle(input in_t p);
		while (!calm && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (pending_count == 0);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] cz, input logic [31:0] rd);
		drain();
		write_reg(CFG_CENTRE_X, cx);
		write_reg(CFG_CENTRE_Y, cy);
		write_reg(CFG_CENTRE_Z, cz);
		write_reg(CFG_CAPTURE_RADIUS, rd);
		cfg_valid <= 1'b0;
		cur_x = cx;
		cur_y = cy;
		cur_z = cz;
	endtask

	task automatic random_particle(input logic last);
		in_t p;
		int  pick;
		pick = $urandom_range(99);
		p = particle(scatter(cur_x), scatter(cur_y), scatter(cur_z), $urandom, last);
		if (pick < 15) begin
			p.pos_x = $urandom;
			p.pos_y = $urandom;
			p.pos_z = $urandom;
		end else if (pick < 25) begin
			p.pos_x = cur_x;
			p.pos_y = cur_y;
			p.pos_z = cur_z;
		end
		if ($urandom_range(9) == 0)
			p.mass = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
		send_particle(p);
	endtask

	initial begin
		int run;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_addr <= CFG_CENTRE_X;
		cfg_data <= '0;
		quiet_cycles <= 0;
		calm = 1'b0;
		hold_req = 1'b0;
		cur_x = '0;
		cur_y = '0;
		cur_z = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// registers at reset: zero radius keeps everything
		send_particle(particle(32'h0, 32'h0, 32'h0, 32'h5, 1'b1));
		send_particle(particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		send_particle(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1));

		// extreme centre and radius: saturated distance, boundary
		configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_particle(particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234, 1'b0));
		send_particle(particle(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
		send_particle(particle(32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
		send_particle(particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
		send_particle(particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
		send_particle(particle(32'h8000_0001, 32'h7FFF_FFFE, 32'h8000_0001, 32'hFFFF_FFFF, 1'b1));

		// unit radius about the origin: new radius above and at the floor
		configure(32'h0, 32'h0, 32'h0, 32'h0001_0000);
		send_particle(particle(32'h0010_0000, 32'h0, 32'h0, 32'h0, 1'b1));
		send_particle(particle(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0));
		send_particle(particle(32'h0000_FFFF, 32'h0, 32'h0, 32'h1, 1'b0));
		send_particle(particle(32'h0, 32'hFFFF_0000, 32'h0, 32'h2, 1'b0));
		send_particle(particle(32'h0, 32'h0, 32'h8000_0000, 32'h3, 1'b1));
		send_particle(particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));

		run = 0;
		for (int ph = 0; ph < 6; ph++) begin
			configure(pick_coord(), pick_coord(), pick_coord(), pick_radius());
			calm = (ph == 2);
			if (ph == 1)
				hold_req = 1'b1;
			for (int n = 0; n < 150; n++) begin
				if (run == 0)
					run = ($urandom_range(7) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 10);
				run--;
				if (ph == 3 && n == 70)
					drain();
				random_particle(run == 0);
			end
		end
		calm = 1'b0;

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("particle_capture_filter: match");
		else
			$display("particle_capture_filter: mismatch");
		$finish;
	end

endmodule
